### rtl/core/mrts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrts_pkg
// Shared types, constants and the mode decoder of the multi-rate scheduler.
// ----------------------------------------------------------------------------
package mrts_pkg;

  // Default widths for time and period values
  localparam int TIME_BITS_DEF   = 48;
  localparam int PERIOD_BITS_DEF = 32;

  // Fixed field widths
  localparam int MODE_BITS     = 3;
  localparam int MASK_BITS     = 9;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CHANNELS      = 4;

  // Period register value after reset
  localparam int unsigned PERIOD_RESET = 32'd100000;

  // Operating modes
  localparam logic [MODE_BITS-1:0] MODE_IDLE     = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_ADAS     = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_FSD      = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_MAPPING  = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_TRACKING = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_ERROR    = 3'd5;

  // Workload mask bit positions
  localparam int WL_SENSORS   = 0;
  localparam int WL_ELEVATION = 1;
  localparam int WL_SLAM      = 2;
  localparam int WL_GLOBAL    = 3;
  localparam int WL_LOCAL     = 4;
  localparam int WL_DETECTION = 5;
  localparam int WL_COMMAND   = 6;
  localparam int WL_MAPWRITER = 7;
  localparam int WL_TRACKING  = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_ELEVATION = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SLAM      = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PLANNER   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DETECTION = 2'd3;

  // Channel slots
  localparam int CH_ELEVATION = 0;
  localparam int CH_SLAM      = 1;
  localparam int CH_PLANNER   = 2;
  localparam int CH_DETECTION = 3;

  // Per-tick action of one channel
  typedef enum logic [1:0] {
    ACT_HOLD  = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_ARM   = 2'd2,
    ACT_ADV   = 2'd3
  } ch_act_t;

  // Sequencer strobes broadcast to the channels
  typedef struct packed {
    logic start;
    logic step;
    logic finish;
  } mrts_ctrl_t;

  // Decode an operating mode into its workload mask
  function automatic logic [MASK_BITS-1:0] mode_mask(input logic [MODE_BITS-1:0] mode);
    logic [MASK_BITS-1:0] m;
    m = '0;
    case (mode)
      MODE_ADAS: begin
        m[WL_SENSORS] = 1'b1; m[WL_ELEVATION] = 1'b1; m[WL_SLAM] = 1'b1;
        m[WL_GLOBAL] = 1'b1; m[WL_LOCAL] = 1'b1; m[WL_DETECTION] = 1'b1;
        m[WL_COMMAND] = 1'b1;
      end
      MODE_FSD: begin
        m[WL_SENSORS] = 1'b1; m[WL_ELEVATION] = 1'b1; m[WL_SLAM] = 1'b1;
        m[WL_GLOBAL] = 1'b1; m[WL_LOCAL] = 1'b1; m[WL_COMMAND] = 1'b1;
      end
      MODE_MAPPING: begin
        m[WL_SENSORS] = 1'b1; m[WL_ELEVATION] = 1'b1; m[WL_SLAM] = 1'b1;
        m[WL_MAPWRITER] = 1'b1;
      end
      MODE_TRACKING: begin
        m[WL_SENSORS] = 1'b1; m[WL_ELEVATION] = 1'b1; m[WL_DETECTION] = 1'b1;
        m[WL_TRACKING] = 1'b1; m[WL_COMMAND] = 1'b1;
      end
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

### rtl/core/mrts_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrts_in_if
// Tick channel: operating mode and current time, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mrts_in_if
  import mrts_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [MODE_BITS-1:0] mode;
  logic [TIME_BITS-1:0] now;

  modport source (output valid, mode, now, input ready);
  modport sink   (input valid, mode, now, output ready);
endinterface

### rtl/core/mrts_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrts_out_if
// Result channel: workload mask and per-channel due flags.
// ----------------------------------------------------------------------------
interface mrts_out_if
  import mrts_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [MASK_BITS-1:0] workload_mask;
  logic                 sensor_on;
  logic                 elev_fire;
  logic                 slam_fire;
  logic                 plan_fire;
  logic                 detect_fire;

  modport source (output valid, workload_mask, sensor_on, elev_fire,
                  slam_fire, plan_fire, detect_fire, input ready);
  modport sink   (input valid, workload_mask, sensor_on, elev_fire,
                  slam_fire, plan_fire, detect_fire, output ready);
endinterface

### rtl/core/mrts_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrts_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mrts_cfg_if
  import mrts_pkg::*;
#(
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [PERIOD_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/multi_rate_task_scheduler.sv
`timescale 1ns / 1ps
// A taken tick runs through S_RUN, where each channel's bit-serial remainder
//   takes one time bit per cycle, then S_DONE, which loads the output register
//   once it is free; no new tick is taken until the sequencer is back in S_IDLE.
// A new tick is taken while the previous result waits in the output register.
// Reset (rst_n, synchronous): channels disarmed, periods 100000, no result.
// ----------------------------------------------------------------------------
// multi_rate_task_scheduler
// Decodes the operating mode and runs four periodic channels per tick.
// ----------------------------------------------------------------------------
module multi_rate_task_scheduler
  import mrts_pkg::*;
#(
  parameter int TIME_BITS   = TIME_BITS_DEF,
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mrts_in_if.sink    in_ch,
  mrts_out_if.source out_ch,
  mrts_cfg_if.sink   cfg_ch
);

  localparam int CNT_W = $clog2(TIME_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_BITS - 1);
  localparam logic [PERIOD_BITS-1:0] PRST = PERIOD_BITS'(PERIOD_RESET);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [PERIOD_BITS-1:0] period_r [CHANNELS];
  logic [MASK_BITS-1:0]   in_mask;
  logic [MASK_BITS-1:0]   mask_r;
  logic [CHANNELS-1:0]    ch_en;
  logic [CHANNELS-1:0]    ch_due;
  logic                   in_take;
  logic                   load_out;
  logic                   out_valid_r, out_valid_nxt;
  logic [MASK_BITS-1:0]   out_mask_r;
  logic [CHANNELS-1:0]    out_due_r;
  mrts_ctrl_t             ctrl;

  // Configuration writes are always taken
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        period_r[i] <= PRST;
      end
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ELEVATION: period_r[CH_ELEVATION] <= cfg_ch.data;
        REG_SLAM:      period_r[CH_SLAM]      <= cfg_ch.data;
        REG_PLANNER:   period_r[CH_PLANNER]   <= cfg_ch.data;
        REG_DETECTION: period_r[CH_DETECTION] <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Decode the mode of the incoming tick
  assign in_mask = mode_mask(in_ch.mode);
  assign ch_en[CH_ELEVATION] = in_mask[WL_ELEVATION];
  assign ch_en[CH_SLAM]      = in_mask[WL_SLAM];
  assign ch_en[CH_PLANNER]   = in_mask[WL_GLOBAL] & in_mask[WL_LOCAL];
  assign ch_en[CH_DETECTION] = in_mask[WL_DETECTION];

  // Sequencer: take a tick, shift the remainders, then publish
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign load_out    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_RUN;
          cnt_nxt   = '0;
        end
      end
      S_RUN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign ctrl.start  = in_take;
  assign ctrl.step   = (state_r == S_RUN);
  assign ctrl.finish = load_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Hold the mask of the tick at work
  always_ff @(posedge clk) begin
    if (in_take) begin
      mask_r <= in_mask;
    end
  end

  // Channel lanes
  for (genvar g = 0; g < CHANNELS; g++) begin : g_ch
    mrts_channel #(
      .TIME_BITS   (TIME_BITS),
      .PERIOD_BITS (PERIOD_BITS)
    ) u_channel (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl),
      .enable (ch_en[g]),
      .now    (in_ch.now),
      .period (period_r[g]),
      .due    (ch_due[g])
    );
  end

  // Output register: load on finish, drop on transaction
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_mask_r <= mask_r;
      out_due_r  <= ch_due;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.workload_mask = out_mask_r;
  assign out_ch.sensor_on     = out_mask_r[WL_SENSORS];
  assign out_ch.elev_fire     = out_due_r[CH_ELEVATION];
  assign out_ch.slam_fire     = out_due_r[CH_SLAM];
  assign out_ch.plan_fire     = out_due_r[CH_PLANNER];
  assign out_ch.detect_fire   = out_due_r[CH_DETECTION];

  // Checks on the sequencer and result
  a_take_runs: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == S_RUN))
    else $error("tick taken without entering run");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) && (cnt_r == CNT_LAST) |=> (state_r == S_DONE))
    else $error("run did not end after the last time bit");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r)
    else $error("result loaded but not offered");

  a_planner_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_due_r[CH_PLANNER] |->
      (out_mask_r[WL_GLOBAL] && out_mask_r[WL_LOCAL]))
    else $error("planner due without both planner workloads");

endmodule

### rtl/core/mrts_rem_serial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrts_rem_serial
// Bit-serial restoring remainder: one dividend bit per step, MSB first.
// ----------------------------------------------------------------------------
module mrts_rem_serial
  import mrts_pkg::*;
#(
  parameter int TIME_BITS   = TIME_BITS_DEF,
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   load,
  input  logic                   step,
  input  logic [TIME_BITS-1:0]   dividend,
  input  logic [PERIOD_BITS-1:0] divisor,
  output logic [PERIOD_BITS-1:0] rem
);

  logic [TIME_BITS-1:0]   shift_r, shift_nxt;
  logic [PERIOD_BITS-1:0] rem_r, rem_nxt;
  logic [PERIOD_BITS:0]   trial;

  // Shift in the next dividend bit and subtract the divisor when it fits
  always_comb begin
    trial     = {rem_r, shift_r[TIME_BITS-1]};
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    if (load) begin
      shift_nxt = dividend;
      rem_nxt   = '0;
    end else if (step) begin
      shift_nxt = {shift_r[TIME_BITS-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = PERIOD_BITS'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[PERIOD_BITS-1:0];
      end
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
  end

  assign rem = rem_r;

endmodule

### rtl/core/mrts_channel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrts_channel
// One periodic channel: next-due time, due decision and catch-up update.
// ----------------------------------------------------------------------------
module mrts_channel
  import mrts_pkg::*;
#(
  parameter int TIME_BITS   = TIME_BITS_DEF,
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mrts_ctrl_t             ctrl,
  input  logic                   enable,
  input  logic [TIME_BITS-1:0]   now,
  input  logic [PERIOD_BITS-1:0] period,
  output logic                   due
);

  localparam int SW = ((TIME_BITS > PERIOD_BITS) ? TIME_BITS : PERIOD_BITS) + 1;
  localparam logic [SW-1:0] TMAX = SW'({TIME_BITS{1'b1}});

  logic [TIME_BITS-1:0]   next_due_r, next_due_nxt;
  logic [TIME_BITS-1:0]   now_r;
  ch_act_t                act_r, act_nxt;
  logic                   due_r, due_nxt;
  logic [PERIOD_BITS-1:0] p_eff;
  logic [PERIOD_BITS-1:0] rem;
  logic [TIME_BITS-1:0]   dividend;
  logic [SW-1:0]          sum;

  // Zero period counts as one
  assign p_eff = (period == '0) ? PERIOD_BITS'(1) : period;

  // Decide this tick's action when it starts
  always_comb begin
    act_nxt = act_r;
    due_nxt = due_r;
    if (ctrl.start) begin
      if (!enable) begin
        act_nxt = ACT_CLEAR;
        due_nxt = 1'b0;
      end else if (next_due_r == '0) begin
        act_nxt = ACT_ARM;
        due_nxt = 1'b1;
      end else if (now >= next_due_r) begin
        act_nxt = ACT_ADV;
        due_nxt = 1'b1;
      end else begin
        act_nxt = ACT_HOLD;
        due_nxt = 1'b0;
      end
    end
  end

  // Arming uses a zero remainder, so feed a zero dividend
  assign dividend = (act_nxt == ACT_ADV) ? (now - next_due_r) : '0;

  mrts_rem_serial #(
    .TIME_BITS   (TIME_BITS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_rem (
    .clk      (clk),
    .load     (ctrl.start),
    .step     (ctrl.step),
    .dividend (dividend),
    .divisor  (p_eff),
    .rem      (rem)
  );

  // New due time is now minus remainder plus one period, saturated
  assign sum = SW'(now_r) - SW'(rem) + SW'(p_eff);

  always_comb begin
    next_due_nxt = next_due_r;
    if (ctrl.finish) begin
      case (act_r)
        ACT_CLEAR: next_due_nxt = '0;
        ACT_ARM, ACT_ADV: begin
          next_due_nxt = (sum > TMAX) ? TMAX[TIME_BITS-1:0] : sum[TIME_BITS-1:0];
        end
        default: next_due_nxt = next_due_r;
      endcase
    end
  end

  // Next-due time resets to not armed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_due_r <= '0;
      act_r      <= ACT_HOLD;
      due_r      <= 1'b0;
    end else begin
      next_due_r <= next_due_nxt;
      act_r      <= act_nxt;
      due_r      <= due_nxt;
    end
  end

  // Capture the tick time
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      now_r <= now;
    end
  end

  assign due = due_r;

endmodule
